[design/assert_macros.svh]
// Assertion macros shared by the hash unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

[design/mh2_pkg.sv]
// Types and constants shared by the MurmurHash2 unit.
`timescale 1ns / 1ps

package mh2_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT   = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;
   localparam logic [31:0] SEED_RESET  = 32'h726f7373;

   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic        REG_SEED_IDX = 1'b0;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_TAIL,
      KIND_FULL
   } kind_type;

   // One classified request as it sits in the queue.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] data;   // word, tail already masked
      logic        start;  // first request of a message
      logic [31:0] init;   // seed ^ total length, used when start
      logic        last;
   } op_type;

endpackage

[design/mh2_front.sv]
// Front end: accepts requests, tracks message boundaries, classifies words.
`timescale 1ns / 1ps

module mh2_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         seed,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_word,
   input  logic [2:0]          req_byte_count,
   input  logic [30:0]         req_total_len,
   input  logic                req_last,
   input  logic                queue_full,
   output logic                push,
   output mh2_pkg::op_type     push_op
);
   import mh2_pkg::*;

   logic in_message_ff;
   logic in_message_in;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_op.start = !in_message_ff;
      push_op.init  = seed ^ {1'b0, req_total_len};
      push_op.last  = req_last;
      case (req_byte_count) inside
         3'd0: begin
            push_op.kind = KIND_NONE;
            push_op.data = '0;
         end
         3'd1: begin
            push_op.kind = KIND_TAIL;
            push_op.data = {24'd0, req_word[7:0]};
         end
         3'd2: begin
            push_op.kind = KIND_TAIL;
            push_op.data = {16'd0, req_word[15:0]};
         end
         3'd3: begin
            push_op.kind = KIND_TAIL;
            push_op.data = {8'd0, req_word[23:0]};
         end
         default: begin
            // four or more counts as a full word
            push_op.kind = KIND_FULL;
            push_op.data = req_word;
         end
      endcase
   end

   always_comb begin
      in_message_in = in_message_ff;
      if (push) begin
         in_message_in = !req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
      end
   end

endmodule

[design/mh2_queue.sv]
// Short request queue between front and back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mh2_queue #(
   parameter int DEPTH = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  mh2_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            op_valid,
   output mh2_pkg::op_type op
);
   import mh2_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign op_valid = (count_ff != '0);
   assign op       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   `ASSERT_HOLDS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `ASSERT_NEVER(a_pop_empty, pop && (count_ff == '0), "pop from empty queue")
   `ASSERT_HOLDS(a_count_up, (push && !pop) |=> count_ff == $past(count_ff) + 1'b1, "count lost a push")

endmodule

[design/mh2_back.sv]
// Back end: mixes queued words into the running hash and finishes messages.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mh2_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  mh2_pkg::op_type op,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [31:0]     rsp_hash
);
   import mh2_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MIX,
      S_FIN,
      S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;     // key after first multiply
   logic [31:0] hm_ff, hm_in;   // hash times MIX_MUL
   logic [31:0] f_ff, f_in;     // finish after its multiply
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic [31:0] base;
   logic [31:0] kx;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      hm_in        = hm_ff;
      f_in         = f_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      pop          = 1'b0;
      base         = op.start ? op.init : h_ff;
      kx           = k_ff ^ (k_ff >> MIX_SHIFT);
      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               pop     = 1'b1;
               last_in = op.last;
               case (op.kind)
                  KIND_FULL: begin
                     k_in     = op.data * MIX_MUL;
                     hm_in    = base * MIX_MUL;
                     state_in = S_MIX;
                  end
                  KIND_TAIL: begin
                     h_in     = (base ^ op.data) * MIX_MUL;
                     state_in = op.last ? S_FIN : S_IDLE;
                  end
                  default: begin
                     h_in     = base;
                     state_in = op.last ? S_FIN : S_IDLE;
                  end
               endcase
            end
         end
         S_MIX: begin
            h_in     = hm_ff ^ (kx * MIX_MUL);
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            f_in     = (h_ff ^ (h_ff >> FIN_SHIFT_A)) * MIX_MUL;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = f_ff ^ (f_ff >> FIN_SHIFT_B);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      h_ff        <= h_in;
      k_ff        <= k_in;
      hm_ff       <= hm_in;
      f_ff        <= f_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   `ASSERT_HOLDS(a_mix_from_idle, (state_ff == S_MIX) |-> ($past(state_ff) == S_IDLE), "mix step not entered from idle")
   `ASSERT_HOLDS(a_fin_entry, (state_ff == S_FIN) |-> ($past(state_ff) == S_IDLE || $past(state_ff) == S_MIX), "finish entered out of order")
   `ASSERT_HOLDS(a_rsp_source, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT), "result raised outside output step")

endmodule

[design/murmur2_hash32_unit.sv]
// Top level of the streaming 32-bit MurmurHash2 unit.
`timescale 1ns / 1ps

// Streaming MurmurHash2 (32-bit). Each request carries up to four message
// bytes, little-endian; the first request of a message also carries the total
// length, which starts the hash as seed ^ length. A request with fewer than
// four bytes adds its tail bytes; zero bytes adds nothing. The request with
// last set produces exactly one response holding the finished hash.
// The front end classifies each request in the cycle it arrives and parks it
// in a QUEUE_DEPTH-entry queue; req_stall rises only when that queue is full.
// The back end drains the queue: a full word gets a mix step (the key's
// two multiplies run in sequence, the hash multiply alongside the first);
// a tail or empty request folds in when popped; the last request adds the
// finish multiply and then the output register load. Nothing pops in a
// mix step, so mixing paces long messages. The response sits in an output
// register, so the back end keeps working while a result waits only until
// the next result is ready. The seed register lives at byte address 0 of
// the APB-style port, resets to 0x726f7373, and is picked up when the
// first request of a message is accepted.

module murmur2_hash32_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_word,
   input  logic [2:0]                      req_byte_count,
   input  logic [30:0]                     req_total_len,
   input  logic                            req_last,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_hash,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mh2_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import mh2_pkg::*;

   logic [31:0] seed_ff, seed_in;
   logic        queue_full;
   logic        push;
   op_type      push_op;
   logic        pop;
   logic        op_valid;
   op_type      op;

   // --- register port: single seed register, no wait states
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SEED_IDX) ? seed_ff : '0;

   always_comb begin
      seed_in = seed_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_SEED_IDX)) begin
         seed_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // --- front end: accept and classify
   mh2_front u_front (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .req_byte_count (req_byte_count),
      .req_total_len  (req_total_len),
      .req_last       (req_last),
      .queue_full     (queue_full),
      .push           (push),
      .push_op        (push_op)
   );

   // --- decoupling queue
   mh2_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_op  (push_op),
      .full     (queue_full),
      .pop      (pop),
      .op_valid (op_valid),
      .op       (op)
   );

   // --- back end: mix, fold, finish
   mh2_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_hash  (rsp_hash)
   );

endmodule
